### hw/rtl/quaternion_rotate_vector_core_assert.svh
// assertion macros for the quaternion rotation core
`ifndef QUATERNION_ROTATE_VECTOR_CORE_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define QRV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked in reset too
`define QRV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRV_ASSERT(label, prop, msg)
`define QRV_ASSERT_RST(label, prop, msg)
`endif

`endif

### hw/rtl/qrv_pkg.sv
// widths, constants and types for the quaternion rotation core
`default_nettype none

package qrv_pkg;

  localparam int COMP_W    = 16;
  localparam int OUT_W     = 18;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int ENTRY_W   = PROD_W + 2;
  localparam int TERM_W    = ENTRY_W + COMP_W;
  localparam int PART_W    = TERM_W + 1;
  localparam int SUM_W     = TERM_W + 2;
  localparam int FRAC_BITS = 28;
  localparam int RND_W     = SUM_W - FRAC_BITS;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [OUT_W-1:0]   res_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [PART_W-1:0]  part_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  localparam part_t ROUND_HALF = PART_W'(64'd1 << (FRAC_BITS - 1));
  localparam rnd_t  RND_MAX    = RND_W'(OUT_MAX);
  localparam rnd_t  RND_MIN    = RND_W'(OUT_MIN);
  localparam res_t  RES_MAX    = OUT_W'(OUT_MAX);
  localparam res_t  RES_MIN    = OUT_W'(OUT_MIN);

endpackage

`default_nettype wire

### hw/rtl/qrv_if.sv
// item and result channels of the quaternion rotation core
`default_nettype none

interface qrv_item_if;
  logic          valid;
  logic          ready;
  qrv_pkg::comp_t q_w;
  qrv_pkg::comp_t q_x;
  qrv_pkg::comp_t q_y;
  qrv_pkg::comp_t q_z;
  qrv_pkg::comp_t vec_x;
  qrv_pkg::comp_t vec_y;
  qrv_pkg::comp_t vec_z;

  modport source (output valid, q_w, q_x, q_y, q_z, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, vec_x, vec_y, vec_z, output ready);
endinterface

interface qrv_result_if;
  logic          valid;
  logic          ready;
  qrv_pkg::res_t out_x;
  qrv_pkg::res_t out_y;
  qrv_pkg::res_t out_z;
  logic          overflow;

  modport source (output valid, out_x, out_y, out_z, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

`default_nettype wire

### hw/rtl/quaternion_rotate_vector_core.sv
// quaternion vector rotation core, six-stage pipeline
//
//  channel  dir  beat
//  item     in   q_w q_x q_y q_z (Q1.14), vec_x vec_y vec_z
//  result   out  out_x out_y out_z (18-bit saturated), overflow
//
//  one item per cycle unless the result channel stalls, six register stages
//  stages: quaternion products, matrix entries, entry times vector,
//  partial sums, round, saturate into the output register
//  each stage advances when it is empty or the stage after it advances,
//  so bubbles collapse and a stalled result holds without loss
//  rst is synchronous and clears only the stage valid bits
`default_nettype none
`include "quaternion_rotate_vector_core_assert.svh"

module quaternion_rotate_vector_core (
  input  wire logic   clk,
  input  wire logic   rst,
  qrv_item_if.sink    item,
  qrv_result_if.source result
);

  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  // stage 1: quaternion products
  qrv_pkg::prod_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  qrv_pkg::comp_t vec1 [3];
  // stage 2: rotation matrix
  qrv_pkg::entry_t m [3][3];
  qrv_pkg::comp_t  vec2 [3];
  // stage 3: entry times vector component
  qrv_pkg::term_t  p [3][3];
  // stage 4: partial sums
  qrv_pkg::part_t  sa [3];
  qrv_pkg::part_t  sb [3];
  // stage 5: rounded rows
  qrv_pkg::sum_t   sum5 [3];
  qrv_pkg::rnd_t   r [3];

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || result.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign item.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= item.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww <= item.q_w * item.q_w;
      xx <= item.q_x * item.q_x;
      yy <= item.q_y * item.q_y;
      zz <= item.q_z * item.q_z;
      xy <= item.q_x * item.q_y;
      xz <= item.q_x * item.q_z;
      yz <= item.q_y * item.q_z;
      wx <= item.q_w * item.q_x;
      wy <= item.q_w * item.q_y;
      wz <= item.q_w * item.q_z;
      vec1[0] <= item.vec_x;
      vec1[1] <= item.vec_y;
      vec1[2] <= item.vec_z;
    end
  end

  function automatic qrv_pkg::entry_t ENTRY_EXT(input qrv_pkg::prod_t a);
    return qrv_pkg::ENTRY_W'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m[0][0] <= ENTRY_EXT(ww) + ENTRY_EXT(xx) - ENTRY_EXT(yy) - ENTRY_EXT(zz);
      m[1][1] <= ENTRY_EXT(ww) - ENTRY_EXT(xx) + ENTRY_EXT(yy) - ENTRY_EXT(zz);
      m[2][2] <= ENTRY_EXT(ww) - ENTRY_EXT(xx) - ENTRY_EXT(yy) + ENTRY_EXT(zz);
      m[0][1] <= (ENTRY_EXT(xy) - ENTRY_EXT(wz)) <<< 1;
      m[0][2] <= (ENTRY_EXT(xz) + ENTRY_EXT(wy)) <<< 1;
      m[1][0] <= (ENTRY_EXT(xy) + ENTRY_EXT(wz)) <<< 1;
      m[1][2] <= (ENTRY_EXT(yz) - ENTRY_EXT(wx)) <<< 1;
      m[2][0] <= (ENTRY_EXT(xz) - ENTRY_EXT(wy)) <<< 1;
      m[2][1] <= (ENTRY_EXT(yz) + ENTRY_EXT(wx)) <<< 1;
      vec2 <= vec1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= qrv_pkg::TERM_W'(m[i][j]) * qrv_pkg::TERM_W'(vec2[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        sa[i] <= qrv_pkg::PART_W'(p[i][0]) + qrv_pkg::PART_W'(p[i][1]);
        sb[i] <= qrv_pkg::PART_W'(p[i][2]) + qrv_pkg::ROUND_HALF;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum5[i] = qrv_pkg::SUM_W'(sa[i]) + qrv_pkg::SUM_W'(sb[i]);
    end
  end

  // dropping the fraction bits is the floor of the half-biased sum
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        r[i] <= sum5[i][qrv_pkg::SUM_W-1:qrv_pkg::FRAC_BITS];
      end
    end
  end

  function automatic qrv_pkg::res_t SAT(input qrv_pkg::rnd_t a);
    if (a > qrv_pkg::RND_MAX) begin
      return qrv_pkg::RES_MAX;
    end else if (a < qrv_pkg::RND_MIN) begin
      return qrv_pkg::RES_MIN;
    end
    return a[qrv_pkg::OUT_W-1:0];
  endfunction

  function automatic logic OVF(input qrv_pkg::rnd_t a);
    return (a > qrv_pkg::RND_MAX) || (a < qrv_pkg::RND_MIN);
  endfunction

  always_ff @(posedge clk) begin
    if (en[5]) begin
      result.out_x    <= SAT(r[0]);
      result.out_y    <= SAT(r[1]);
      result.out_z    <= SAT(r[2]);
      result.overflow <= OVF(r[0]) || OVF(r[1]) || OVF(r[2]);
    end
  end

  assign result.valid = v[NSTAGE-1];

  `QRV_ASSERT(a_ovf_at_rail, result.valid && result.overflow |->
    result.out_x == qrv_pkg::RES_MAX || result.out_x == qrv_pkg::RES_MIN ||
    result.out_y == qrv_pkg::RES_MAX || result.out_y == qrv_pkg::RES_MIN ||
    result.out_z == qrv_pkg::RES_MAX || result.out_z == qrv_pkg::RES_MIN,
    "overflow without a saturated component")
  `QRV_ASSERT(a_no_drop, v[3] && en[4] |=> v[4], "item lost between partial sum and round stages")
  `QRV_ASSERT_RST(a_reset_empty, rst |=> !result.valid && v == '0, "pipeline not empty after reset")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the quaternion rotation core, with its own fixed-point predictor
`default_nettype none

module testbench;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_GAP = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct {
    qrv_pkg::comp_t q_w;
    qrv_pkg::comp_t q_x;
    qrv_pkg::comp_t q_y;
    qrv_pkg::comp_t q_z;
    qrv_pkg::comp_t vec_x;
    qrv_pkg::comp_t vec_y;
    qrv_pkg::comp_t vec_z;
  } rot_item_t;

  typedef struct {
    qrv_pkg::res_t out_x;
    qrv_pkg::res_t out_y;
    qrv_pkg::res_t out_z;
    logic overflow;
  } rot_result_t;

  logic clk;
  logic rst;

  qrv_item_if item_ch();
  qrv_result_if result_ch();

  quaternion_rotate_vector_core dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  rot_result_t pending_rotations[$];
  int err_count = 0;
  int stall_cycles = 0;
  int sink_hold_cycles = 0;
  bit src_idle_on = 1'b0;
  bit snk_idle_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic qrv_pkg::res_t clamp_component(input longint v, inout bit clipped);
    if (v > qrv_pkg::OUT_MAX) begin
      clipped = 1'b1;
      return qrv_pkg::RES_MAX;
    end
    if (v < qrv_pkg::OUT_MIN) begin
      clipped = 1'b1;
      return qrv_pkg::RES_MIN;
    end
    return qrv_pkg::res_t'(v);
  endfunction

  // exact q.28 row sums, rounded half up by arithmetic shift
  function automatic rot_result_t predict_rotation(input rot_item_t it);
    longint w, x, y, z, vx, vy, vz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint half;
    bit clipped;
    rot_result_t r;
    w = it.q_w;
    x = it.q_x;
    y = it.q_y;
    z = it.q_z;
    vx = it.vec_x;
    vy = it.vec_y;
    vz = it.vec_z;
    half = longint'(1) <<< (qrv_pkg::FRAC_BITS - 1);
    clipped = 1'b0;
    m00 = w*w + x*x - y*y - z*z;
    m01 = 2 * (x*y - w*z);
    m02 = 2 * (x*z + w*y);
    m10 = 2 * (x*y + w*z);
    m11 = w*w - x*x + y*y - z*z;
    m12 = 2 * (y*z - w*x);
    m20 = 2 * (x*z - w*y);
    m21 = 2 * (y*z + w*x);
    m22 = w*w - x*x - y*y + z*z;
    r.out_x = clamp_component((m00*vx + m01*vy + m02*vz + half) >>> qrv_pkg::FRAC_BITS, clipped);
    r.out_y = clamp_component((m10*vx + m11*vy + m12*vz + half) >>> qrv_pkg::FRAC_BITS, clipped);
    r.out_z = clamp_component((m20*vx + m21*vy + m22*vz + half) >>> qrv_pkg::FRAC_BITS, clipped);
    r.overflow = clipped;
    return r;
  endfunction

  function automatic rot_item_t make_item(input int w, input int x, input int y, input int z,
                                          input int vx, input int vy, input int vz);
    rot_item_t it;
    it.q_w = qrv_pkg::comp_t'(w);
    it.q_x = qrv_pkg::comp_t'(x);
    it.q_y = qrv_pkg::comp_t'(y);
    it.q_z = qrv_pkg::comp_t'(z);
    it.vec_x = qrv_pkg::comp_t'(vx);
    it.vec_y = qrv_pkg::comp_t'(vy);
    it.vec_z = qrv_pkg::comp_t'(vz);
    return it;
  endfunction

  function automatic int unit_range_comp();
    return int'($urandom_range(32768, 0)) - 16384;
  endfunction

  function automatic int random_vec_comp();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(512, 0)) - 256;
      default: return int'(qrv_pkg::comp_t'($urandom));
    endcase
  endfunction

  function automatic rot_item_t random_item();
    real a, b, c, d, n;
    rot_item_t it;
    it = make_item(0, 0, 0, 0, random_vec_comp(), random_vec_comp(), random_vec_comp());
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // normalized rotation
        a = unit_range_comp();
        b = unit_range_comp();
        c = unit_range_comp();
        d = unit_range_comp();
        n = $sqrt(a*a + b*b + c*c + d*d);
        if (n < 1.0) begin
          it.q_w = qrv_pkg::comp_t'(16384);
        end else begin
          it.q_w = qrv_pkg::comp_t'($rtoi(a / n * 16384.0));
          it.q_x = qrv_pkg::comp_t'($rtoi(b / n * 16384.0));
          it.q_y = qrv_pkg::comp_t'($rtoi(c / n * 16384.0));
          it.q_z = qrv_pkg::comp_t'($rtoi(d / n * 16384.0));
        end
      end
      5, 6, 7: begin
        it.q_w = qrv_pkg::comp_t'(unit_range_comp());
        it.q_x = qrv_pkg::comp_t'(unit_range_comp());
        it.q_y = qrv_pkg::comp_t'(unit_range_comp());
        it.q_z = qrv_pkg::comp_t'(unit_range_comp());
      end
      default: begin
        it.q_w = qrv_pkg::comp_t'($urandom);
        it.q_x = qrv_pkg::comp_t'($urandom);
        it.q_y = qrv_pkg::comp_t'($urandom);
        it.q_z = qrv_pkg::comp_t'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic send_rotation(input rot_item_t it);
    int gap;
    gap = src_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.q_w <= it.q_w;
    item_ch.q_x <= it.q_x;
    item_ch.q_y <= it.q_y;
    item_ch.q_z <= it.q_z;
    item_ch.vec_x <= it.vec_x;
    item_ch.vec_y <= it.vec_y;
    item_ch.vec_z <= it.vec_z;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  task automatic compare_component(input string name,
                                   input logic signed [qrv_pkg::OUT_W-1:0] expv,
                                   input logic signed [qrv_pkg::OUT_W-1:0] act);
    if (act !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, act);
      err_count++;
    end
  endtask

  task automatic test_identity_and_zero();
    send_rotation(make_item(16384, 0, 0, 0, 32767, -32768, 1));
    send_rotation(make_item(16384, 0, 0, 0, -32768, 32767, -1));
    send_rotation(make_item(16384, 0, 0, 0, 0, 0, 0));
    send_rotation(make_item(-16384, 0, 0, 0, 1234, -4321, 32767));
    send_rotation(make_item(0, 0, 0, 0, 32767, 32767, -32768));
    wait_drain();
  endtask

  task automatic test_axis_rotations();
    send_rotation(make_item(11585, 11585, 0, 0, 1000, 2000, 3000));
    send_rotation(make_item(11585, 0, 11585, 0, 1000, 2000, 3000));
    send_rotation(make_item(11585, 0, 0, 11585, 1000, 2000, 3000));
    send_rotation(make_item(0, 16384, 0, 0, -32768, 32767, -32768));
    send_rotation(make_item(0, 0, 16384, 0, -32768, 32767, -32768));
    send_rotation(make_item(0, 0, 0, -16384, -32768, 32767, -32768));
    wait_drain();
  endtask

  // halves land exactly on .5 and round toward plus infinity
  task automatic test_rounding_ties();
    send_rotation(make_item(128, 0, 0, 0, 8192, -8192, 24576));
    send_rotation(make_item(128, 0, 0, 0, -24576, 0, -8192));
    send_rotation(make_item(0, 128, 0, 0, -8192, 24576, 8192));
    wait_drain();
  endtask

  task automatic test_saturation();
    send_rotation(make_item(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_rotation(make_item(-32768, -32768, 0, 0, 32767, -32768, 32767));
    send_rotation(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_rotation(make_item(16384, 16384, 16384, 16384, -32768, 32767, -32768));
    send_rotation(make_item(-32768, 0, 0, 0, 32767, -32768, 0));
    send_rotation(make_item(32767, -32768, 32767, -32768, 32767, 0, -32768));
    wait_drain();
  endtask

  task automatic test_random_rotations();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        src_idle_on = ($urandom_range(0, 1) == 1);
        snk_idle_on = ($urandom_range(0, 1) == 1);
      end
      if (i % 300 == 299) wait_drain();
      send_rotation(random_item());
    end
    wait_drain();
  endtask

  task automatic test_result_backpressure();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    sink_hold_cycles = HOLD_CYCLES;
    repeat (60) send_rotation(random_item());
    wait_drain();
  endtask

  initial begin : result_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else begin
        gap = snk_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    rot_item_t it;
    if (!rst && item_ch.valid && item_ch.ready) begin
      it.q_w = item_ch.q_w;
      it.q_x = item_ch.q_x;
      it.q_y = item_ch.q_y;
      it.q_z = item_ch.q_z;
      it.vec_x = item_ch.vec_x;
      it.vec_y = item_ch.vec_y;
      it.vec_z = item_ch.vec_z;
      pending_rotations.push_back(predict_rotation(it));
    end
  end

  always @(posedge clk) begin
    rot_result_t exp_res;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_rotations.size() == 0) begin
        $error("result beat with no item outstanding");
        err_count++;
      end else begin
        exp_res = pending_rotations.pop_front();
        compare_component("out_x", exp_res.out_x, result_ch.out_x);
        compare_component("out_y", exp_res.out_y, result_ch.out_y);
        compare_component("out_z", exp_res.out_z, result_ch.out_z);
        compare_component("overflow", qrv_pkg::res_t'(exp_res.overflow),
                          qrv_pkg::res_t'(result_ch.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.q_w <= '0;
    item_ch.q_x <= '0;
    item_ch.q_y <= '0;
    item_ch.q_z <= '0;
    item_ch.vec_x <= '0;
    item_ch.vec_y <= '0;
    item_ch.vec_z <= '0;
    result_ch.ready <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_and_zero();
    test_axis_rotations();
    test_rounding_ties();
    test_saturation();
    test_result_backpressure();
    test_random_rotations();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rotations.size() != 0) begin
      $error("%0d results never arrived", pending_rotations.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
